FILE: src/bitmap_id_allocator_deferred_commit_defines.svh
// Assertion macros used by the allocator's top-level RTL file.
// No dependencies; included by files that carry concurrent assertions.
`ifndef BITMAP_ID_ALLOCATOR_DEFERRED_COMMIT_DEFINES_SVH
`define BITMAP_ID_ALLOCATOR_DEFERRED_COMMIT_DEFINES_SVH

`ifndef ASSERT_OFF
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

FILE: src/bia_pkg.sv
// Shared types, field widths and codes of the bitmap ID allocator.
// No dependencies; used by bia_front, bia_back and the top level.
package bia_pkg;

    localparam int ID_COUNT    = 1024;
    localparam int GROUP_BITS  = 64;
    localparam int MAX_RESULTS = 16;
    localparam int QUEUE_DEPTH = 2;

    localparam int KIND_W   = 2;
    localparam int EID_W    = 10;
    localparam int STATUS_W = 2;
    localparam int RID_W    = 10;
    localparam int GRP_W    = 4;
    localparam int MASK_W   = 64;

    localparam logic [KIND_W-1:0] KIND_CREATE = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMMIT = 2'd2;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd3;

    typedef logic [EID_W-1:0]  eid_t;
    typedef logic [RID_W-1:0]  rid_t;
    typedef logic [GRP_W-1:0]  grp_t;
    typedef logic [MASK_W-1:0] mask_t;

    typedef enum logic [1:0] {
        OP_CREATE,
        OP_REMOVE,
        OP_COMMIT,
        OP_QUERY
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK,
        ST_FULL,
        ST_NOT_LIVE,
        ST_NONE
    } status_t;

    typedef struct packed {
        op_t  op;
        eid_t eid;
    } cmd_t;

endpackage

FILE: src/bitmap_id_allocator_deferred_commit.sv
// Top level of the bitmap ID allocator with deferred commit.
// Depends on bia_pkg, bia_front, bia_back and the assertion macro header.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  kind, target_id
//   out      output     out_valid/out_stall  status, result_id, group_index,
//                                            deleted_mask, created_mask, last
//
// Remove is answered straight from the idle state. Create answers at once and, when it
// hands out an ID, then runs a free-ID search, one bitmap group per cycle. A query either
// answers at once or walks the groups up to the one holding the highest used ID. A commit
// walks every group once, with one word per reported group.
// Reset clears both bitmaps at once; there is no clearing pass.
// A two-word command queue and the output register keep input and output stalls apart.
`include "bitmap_id_allocator_deferred_commit_defines.svh"

module bitmap_id_allocator_deferred_commit #(
    parameter int ID_COUNT   = bia_pkg::ID_COUNT,
    parameter int GROUP_BITS = bia_pkg::GROUP_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [bia_pkg::KIND_W-1:0]    kind,
    input  logic [bia_pkg::EID_W-1:0]     target_id,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bia_pkg::STATUS_W-1:0]  status,
    output logic [bia_pkg::RID_W-1:0]     result_id,
    output logic [bia_pkg::GRP_W-1:0]     group_index,
    output logic [bia_pkg::MASK_W-1:0]    deleted_mask,
    output logic [bia_pkg::MASK_W-1:0]    created_mask,
    output logic                          last
);

    logic          cmd_valid;
    logic          cmd_take;
    bia_pkg::cmd_t cmd;
    logic          word_plain;

    bia_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .target_id (target_id),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_take  (cmd_take)
    );

    bia_back #(
        .ID_COUNT   (ID_COUNT),
        .GROUP_BITS (GROUP_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (cmd_valid),
        .cmd          (cmd),
        .cmd_take     (cmd_take),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .result_id    (result_id),
        .group_index  (group_index),
        .deleted_mask (deleted_mask),
        .created_mask (created_mask),
        .last         (last)
    );

    assign word_plain = (status == bia_pkg::ST_OK) && (result_id == '0);

    `ASSERT_IMPLY(a_take_needs_cmd, clk, rst_n, cmd_take, cmd_valid)
    `ASSERT_IMPLY(a_stall_means_queued, clk, rst_n, in_stall, cmd_valid)
    // Only commit words can be followed by more words of the same command.
    `ASSERT_IMPLY(a_nonlast_is_commit, clk, rst_n, out_valid && !last, word_plain)
    `ASSERT_NEXT(a_pop_frees_queue, clk, rst_n, cmd_take && !in_valid, !in_stall)

endmodule

FILE: src/bia_front.sv
// Front end: accepts input words, decodes the kind and buffers commands.
// Depends on bia_pkg; feeds bia_back through a short command queue.
module bia_front (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [bia_pkg::KIND_W-1:0]  kind,
    input  logic [bia_pkg::EID_W-1:0]   target_id,
    output logic                        cmd_valid,
    output bia_pkg::cmd_t               cmd,
    input  logic                        cmd_take
);

    localparam int QDepth = bia_pkg::QUEUE_DEPTH;
    localparam int PtrW   = (QDepth > 1) ? $clog2(QDepth) : 1;
    localparam int CntW   = $clog2(QDepth + 1);

    bia_pkg::cmd_t       queue_reg [QDepth];
    logic [PtrW-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]     count_reg, count_next;
    bia_pkg::cmd_t       decoded;
    logic                push;

    always_comb
    begin
        decoded.eid = target_id;
        case (kind)
            bia_pkg::KIND_CREATE: decoded.op = bia_pkg::OP_CREATE;
            bia_pkg::KIND_REMOVE: decoded.op = bia_pkg::OP_REMOVE;
            bia_pkg::KIND_COMMIT: decoded.op = bia_pkg::OP_COMMIT;
            default:              decoded.op = bia_pkg::OP_QUERY;
        endcase
    end

    assign in_stall  = (count_reg == CntW'(QDepth));
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = queue_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(QDepth - 1)) ? '0 : wr_ptr_reg + PtrW'(1);
        end
        if (cmd_take)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(QDepth - 1)) ? '0 : rd_ptr_reg + PtrW'(1);
        end
        if (push && !cmd_take)
        begin
            count_next = count_reg + CntW'(1);
        end
        else if (!push && cmd_take)
        begin
            count_next = count_reg - CntW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
            if (push)
            begin
                queue_reg[wr_ptr_reg] <= decoded;
            end
        end
    end

endmodule

FILE: src/bia_back.sv
// Back end: holds both bitmaps and runs create, remove, commit and query.
// Depends on bia_pkg; takes commands from bia_front, owns the output register.
module bia_back #(
    parameter int ID_COUNT   = bia_pkg::ID_COUNT,
    parameter int GROUP_BITS = bia_pkg::GROUP_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cmd_valid,
    input  bia_pkg::cmd_t                 cmd,
    output logic                          cmd_take,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [bia_pkg::STATUS_W-1:0]  status,
    output logic [bia_pkg::RID_W-1:0]     result_id,
    output logic [bia_pkg::GRP_W-1:0]     group_index,
    output logic [bia_pkg::MASK_W-1:0]    deleted_mask,
    output logic [bia_pkg::MASK_W-1:0]    created_mask,
    output logic                          last
);

    localparam int NGroups = ID_COUNT / GROUP_BITS;
    localparam int BitW    = $clog2(GROUP_BITS);
    localparam int GrpW    = (NGroups > 1) ? $clog2(NGroups) : 1;
    localparam int HuW     = $clog2(ID_COUNT);
    localparam int LfW     = $clog2(ID_COUNT + 1);
    localparam int EidW    = bia_pkg::EID_W;
    localparam int CalcW   = ((LfW > EidW) ? LfW : EidW) + 1;
    localparam int TopCap  = ((NGroups < bia_pkg::MAX_RESULTS) ? NGroups
                                                               : bia_pkg::MAX_RESULTS) - 1;

    typedef logic [GROUP_BITS-1:0] gword_t;
    typedef enum logic [1:0] {
        S_IDLE,
        S_FILL,
        S_QUERY,
        S_COMMIT
    } state_t;

    gword_t              committed_reg [NGroups];
    gword_t              pending_reg   [NGroups];
    state_t              state_reg, state_next;
    logic [GrpW-1:0]     grp_reg, grp_next;
    logic [GrpW-1:0]     top_reg, top_next;
    logic                first_reg, first_next;
    logic [BitW-1:0]     start_bit_reg, start_bit_next;
    logic [HuW-1:0]      highest_used_reg, highest_used_next;
    logic [LfW-1:0]      lowest_free_reg, lowest_free_next;

    logic                out_valid_reg, out_valid_next;
    bia_pkg::status_t    status_reg, status_next;
    bia_pkg::rid_t       rid_reg, rid_next;
    bia_pkg::grp_t       gidx_reg, gidx_next;
    bia_pkg::mask_t      del_reg, del_next;
    bia_pkg::mask_t      cre_reg, cre_next;
    logic                last_reg, last_next;

    logic [GrpW-1:0]     rd_grp;
    gword_t              rd_c, rd_p;
    gword_t              smask, sel_vec, low_vec;
    logic [BitW-1:0]     ffs_idx;
    logic                ffs_any;
    logic [CalcW-1:0]    found_id, hu_ext, lf_ext, eid_ext, start_id;
    logic [GrpW-1:0]     hu_grp;
    logic [BitW-1:0]     eid_bit, lf_bit;
    logic                out_free;
    logic                last_grp;
    logic                pend_we, comm_we;
    gword_t              pend_wdata;

    logic                emit;
    bia_pkg::status_t    e_status;
    logic [CalcW-1:0]    e_id;
    logic [GrpW-1:0]     e_grp;
    gword_t              e_del, e_cre;
    logic                e_last;

    assign hu_ext   = CalcW'(highest_used_reg);
    assign lf_ext   = CalcW'(lowest_free_reg);
    assign eid_ext  = CalcW'(cmd.eid);
    assign hu_grp   = hu_ext[BitW +: GrpW];
    assign eid_bit  = eid_ext[BitW-1:0];
    assign lf_bit   = lf_ext[BitW-1:0];
    assign out_free = !out_valid_reg || !out_stall;
    assign last_grp = (grp_reg == GrpW'(NGroups - 1));

    always_comb
    begin
        if (state_reg == S_IDLE)
        begin
            rd_grp = (cmd.op == bia_pkg::OP_CREATE) ? lf_ext[BitW +: GrpW]
                                                    : eid_ext[BitW +: GrpW];
        end
        else
        begin
            rd_grp = grp_reg;
        end
    end

    assign rd_c  = committed_reg[rd_grp];
    assign rd_p  = pending_reg[rd_grp];
    assign smask = first_reg ? ({GROUP_BITS{1'b1}} << start_bit_reg) : {GROUP_BITS{1'b1}};

    always_comb
    begin
        case (state_reg)
            S_FILL:   sel_vec = ~(rd_c | rd_p) & smask;
            S_QUERY:  sel_vec = rd_c & smask;
            S_COMMIT: sel_vec = ~rd_p & smask;
            default:  sel_vec = '0;
        endcase
    end

    always_comb
    begin
        low_vec = sel_vec & (~sel_vec + gword_t'(1));
        ffs_any = |sel_vec;
        ffs_idx = '0;
        for (int i = 0; i < GROUP_BITS; i++)
        begin
            if (low_vec[i])
            begin
                ffs_idx = ffs_idx | BitW'(i);
            end
        end
    end

    assign found_id = (CalcW'(grp_reg) << BitW) | CalcW'(ffs_idx);

    always_comb
    begin
        state_next        = state_reg;
        grp_next          = grp_reg;
        top_next          = top_reg;
        first_next        = first_reg;
        start_bit_next    = start_bit_reg;
        highest_used_next = highest_used_reg;
        lowest_free_next  = lowest_free_reg;
        cmd_take          = 1'b0;
        pend_we           = 1'b0;
        pend_wdata        = rd_p;
        comm_we           = 1'b0;
        emit              = 1'b0;
        e_status          = bia_pkg::ST_OK;
        e_id              = '0;
        e_grp             = '0;
        e_del             = '0;
        e_cre             = '0;
        e_last            = 1'b1;
        start_id          = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (cmd_valid && out_free)
                begin
                    cmd_take = 1'b1;
                    case (cmd.op)
                        bia_pkg::OP_CREATE:
                        begin
                            emit = 1'b1;
                            if (lf_ext >= CalcW'(ID_COUNT))
                            begin
                                e_status = bia_pkg::ST_FULL;
                            end
                            else
                            begin
                                e_id       = lf_ext;
                                pend_we    = 1'b1;
                                pend_wdata = rd_p | (gword_t'(1) << lf_bit);
                                if (lf_ext > hu_ext)
                                begin
                                    highest_used_next = HuW'(lf_ext);
                                end
                                start_id = lf_ext + CalcW'(1);
                                if (start_id >= CalcW'(ID_COUNT))
                                begin
                                    lowest_free_next = LfW'(ID_COUNT);
                                end
                                else
                                begin
                                    grp_next       = start_id[BitW +: GrpW];
                                    start_bit_next = start_id[BitW-1:0];
                                    first_next     = 1'b1;
                                    state_next     = S_FILL;
                                end
                            end
                        end
                        bia_pkg::OP_REMOVE:
                        begin
                            emit = 1'b1;
                            if (cmd.eid == '0 || eid_ext >= CalcW'(ID_COUNT) || !rd_c[eid_bit])
                            begin
                                e_status = bia_pkg::ST_NOT_LIVE;
                            end
                            else
                            begin
                                pend_we    = 1'b1;
                                pend_wdata = rd_p & ~(gword_t'(1) << eid_bit);
                            end
                        end
                        bia_pkg::OP_COMMIT:
                        begin
                            top_next         = (hu_grp > GrpW'(TopCap)) ? GrpW'(TopCap) : hu_grp;
                            grp_next         = '0;
                            first_next       = 1'b1;
                            start_bit_next   = BitW'(1);
                            lowest_free_next = LfW'(ID_COUNT);
                            state_next       = S_COMMIT;
                        end
                        default:
                        begin
                            start_id = eid_ext + CalcW'(1);
                            if (start_id >= CalcW'(ID_COUNT) || start_id > hu_ext)
                            begin
                                emit     = 1'b1;
                                e_status = bia_pkg::ST_NONE;
                            end
                            else
                            begin
                                grp_next       = start_id[BitW +: GrpW];
                                start_bit_next = start_id[BitW-1:0];
                                first_next     = 1'b1;
                                state_next     = S_QUERY;
                            end
                        end
                    endcase
                end
            end
            S_FILL:
            begin
                if (ffs_any)
                begin
                    lowest_free_next = LfW'(found_id);
                    state_next       = S_IDLE;
                end
                else if (last_grp)
                begin
                    lowest_free_next = LfW'(ID_COUNT);
                    state_next       = S_IDLE;
                end
                else
                begin
                    grp_next   = grp_reg + GrpW'(1);
                    first_next = 1'b0;
                end
            end
            S_QUERY:
            begin
                if (ffs_any || grp_reg == hu_grp)
                begin
                    if (out_free)
                    begin
                        emit       = 1'b1;
                        state_next = S_IDLE;
                        if (ffs_any && found_id <= hu_ext)
                        begin
                            e_id = found_id;
                        end
                        else
                        begin
                            e_status = bia_pkg::ST_NONE;
                        end
                    end
                end
                else
                begin
                    grp_next   = grp_reg + GrpW'(1);
                    first_next = 1'b0;
                end
            end
            S_COMMIT:
            begin
                if (grp_reg > top_reg || out_free)
                begin
                    comm_we = 1'b1;
                    if (grp_reg <= top_reg)
                    begin
                        emit   = 1'b1;
                        e_grp  = grp_reg;
                        e_del  = rd_c & ~rd_p;
                        e_cre  = rd_p & ~rd_c;
                        e_last = (grp_reg == top_reg);
                    end
                    if (ffs_any && lowest_free_reg == LfW'(ID_COUNT))
                    begin
                        lowest_free_next = LfW'(found_id);
                    end
                    if (last_grp)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        grp_next   = grp_reg + GrpW'(1);
                        first_next = 1'b0;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = emit || (out_valid_reg && out_stall);
        status_next    = status_reg;
        rid_next       = rid_reg;
        gidx_next      = gidx_reg;
        del_next       = del_reg;
        cre_next       = cre_reg;
        last_next      = last_reg;
        if (emit)
        begin
            status_next = e_status;
            rid_next    = bia_pkg::rid_t'(e_id);
            gidx_next   = bia_pkg::grp_t'(e_grp);
            del_next    = bia_pkg::mask_t'(e_del);
            cre_next    = bia_pkg::mask_t'(e_cre);
            last_next   = e_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            grp_reg          <= '0;
            top_reg          <= '0;
            first_reg        <= 1'b0;
            start_bit_reg    <= '0;
            highest_used_reg <= '0;
            lowest_free_reg  <= LfW'(1);
            out_valid_reg    <= 1'b0;
            status_reg       <= bia_pkg::ST_OK;
            rid_reg          <= '0;
            gidx_reg         <= '0;
            del_reg          <= '0;
            cre_reg          <= '0;
            last_reg         <= 1'b0;
            for (int g = 0; g < NGroups; g++)
            begin
                committed_reg[g] <= '0;
                pending_reg[g]   <= '0;
            end
        end
        else
        begin
            state_reg        <= state_next;
            grp_reg          <= grp_next;
            top_reg          <= top_next;
            first_reg        <= first_next;
            start_bit_reg    <= start_bit_next;
            highest_used_reg <= highest_used_next;
            lowest_free_reg  <= lowest_free_next;
            out_valid_reg    <= out_valid_next;
            status_reg       <= status_next;
            rid_reg          <= rid_next;
            gidx_reg         <= gidx_next;
            del_reg          <= del_next;
            cre_reg          <= cre_next;
            last_reg         <= last_next;
            if (pend_we)
            begin
                pending_reg[rd_grp] <= pend_wdata;
            end
            if (comm_we)
            begin
                committed_reg[rd_grp] <= rd_p;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign status       = status_reg;
    assign result_id    = rid_reg;
    assign group_index  = gidx_reg;
    assign deleted_mask = del_reg;
    assign created_mask = cre_reg;
    assign last         = last_reg;

endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the bitmap ID allocator with deferred commit.
// It predicts every reply word from its own copy of both bitmaps and checks replies in order.
// Depends on bia_pkg and the top level bitmap_id_allocator_deferred_commit.
`timescale 1ns / 1ps

typedef struct {
    bia_pkg::status_t st;
    bia_pkg::rid_t    rid;
    bia_pkg::grp_t    grp;
    bia_pkg::mask_t   del;
    bia_pkg::mask_t   cre;
    logic             fin;
} reply_t;

class id_allocation_tracker;
    localparam int GROUPS = bia_pkg::ID_COUNT / bia_pkg::GROUP_BITS;

    bia_pkg::mask_t live_now[GROUPS];
    bia_pkg::mask_t live_next[GROUPS];
    int             top_used;
    int             first_free;
    reply_t         awaited_replies[$];
    int             mismatches;
    int             replies_seen;

    function new();
        foreach (live_now[g])
        begin
            live_now[g] = '0;
            live_next[g] = '0;
        end
        top_used = 0;
        first_free = 1;
        mismatches = 0;
        replies_seen = 0;
    endfunction

    function bit in_now(int id);
        return id < bia_pkg::ID_COUNT &&
               live_now[id / bia_pkg::GROUP_BITS][id % bia_pkg::GROUP_BITS];
    endfunction

    function bit in_next(int id);
        return id < bia_pkg::ID_COUNT &&
               live_next[id / bia_pkg::GROUP_BITS][id % bia_pkg::GROUP_BITS];
    endfunction

    function void queue_reply(bia_pkg::status_t st, int rid, int grp, bia_pkg::mask_t del,
                              bia_pkg::mask_t cre, bit fin);
        reply_t r;
        r.st = st;
        r.rid = bia_pkg::rid_t'(rid);
        r.grp = bia_pkg::grp_t'(grp);
        r.del = del;
        r.cre = cre;
        r.fin = fin;
        awaited_replies.push_back(r);
    endfunction

    function void note_request(logic [bia_pkg::KIND_W-1:0] k, bia_pkg::eid_t e);
        int id;
        int top;
        bit found;
        case (k)
            bia_pkg::KIND_CREATE:
            begin
                if (first_free == 0 || first_free >= bia_pkg::ID_COUNT)
                    queue_reply(bia_pkg::ST_FULL, 0, 0, '0, '0, 1'b1);
                else
                begin
                    id = first_free;
                    live_next[id / bia_pkg::GROUP_BITS][id % bia_pkg::GROUP_BITS] = 1'b1;
                    if (id > top_used)
                        top_used = id;
                    first_free = id + 1;
                    while (first_free < bia_pkg::ID_COUNT &&
                           (in_now(first_free) || in_next(first_free)))
                        first_free++;
                    queue_reply(bia_pkg::ST_OK, id, 0, '0, '0, 1'b1);
                end
            end
            bia_pkg::KIND_REMOVE:
            begin
                if (e == 0 || !in_now(int'(e)))
                    queue_reply(bia_pkg::ST_NOT_LIVE, 0, 0, '0, '0, 1'b1);
                else
                begin
                    live_next[e / bia_pkg::GROUP_BITS][e % bia_pkg::GROUP_BITS] = 1'b0;
                    queue_reply(bia_pkg::ST_OK, 0, 0, '0, '0, 1'b1);
                end
            end
            bia_pkg::KIND_COMMIT:
            begin
                top = top_used / bia_pkg::GROUP_BITS;
                if (top >= GROUPS)
                    top = GROUPS - 1;
                if (top >= bia_pkg::MAX_RESULTS)
                    top = bia_pkg::MAX_RESULTS - 1;
                for (int g = 0; g <= top; g++)
                    queue_reply(bia_pkg::ST_OK, 0, g, live_now[g] & ~live_next[g],
                                live_next[g] & ~live_now[g], g == top);
                live_now = live_next;
                first_free = 1;
                while (first_free < bia_pkg::ID_COUNT && in_next(first_free))
                    first_free++;
            end
            default:
            begin
                found = 1'b0;
                for (id = int'(e) + 1; id <= top_used && id < bia_pkg::ID_COUNT; id++)
                begin
                    if (in_now(id))
                    begin
                        found = 1'b1;
                        break;
                    end
                end
                if (found)
                    queue_reply(bia_pkg::ST_OK, id, 0, '0, '0, 1'b1);
                else
                    queue_reply(bia_pkg::ST_NONE, 0, 0, '0, '0, 1'b1);
            end
        endcase
    endfunction

    function void check_reply(logic [bia_pkg::STATUS_W-1:0] st, bia_pkg::rid_t rid,
                              bia_pkg::grp_t grp, bia_pkg::mask_t del,
                              bia_pkg::mask_t cre, logic fin);
        reply_t want;
        replies_seen++;
        if (awaited_replies.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("word %0d arrived with nothing awaited: st %0d id %0d grp %0d last %0d",
                         replies_seen, st, rid, grp, fin);
            return;
        end
        want = awaited_replies.pop_front();
        if (st !== want.st || rid !== want.rid || grp !== want.grp || del !== want.del ||
            cre !== want.cre || fin !== want.fin)
        begin
            mismatches++;
            if (mismatches <= 10)
            begin
                $display("word %0d mismatch: expected st %0d id %0d grp %0d last %0d",
                         replies_seen, want.st, want.rid, want.grp, want.fin);
                $display("    expected deleted %h created %h", want.del, want.cre);
                $display("    actual st %0d id %0d grp %0d last %0d", st, rid, grp, fin);
                $display("    actual deleted %h created %h", del, cre);
            end
        end
    endfunction

    function int pick_live();
        int ids[$];
        for (int id = 1; id < bia_pkg::ID_COUNT; id++)
        begin
            if (in_now(id))
                ids.push_back(id);
        end
        if (ids.size() == 0)
            return $urandom_range(1, bia_pkg::ID_COUNT - 1);
        return ids[$urandom_range(0, ids.size() - 1)];
    endfunction
endclass

module testbench;
    localparam int IDLE_LIMIT = 2000;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic                         in_valid = 1'b0;
    logic                         in_stall;
    logic [bia_pkg::KIND_W-1:0]   kind = bia_pkg::KIND_CREATE;
    logic [bia_pkg::EID_W-1:0]    target_id = '0;
    logic                         out_valid;
    logic                         out_stall = 1'b0;
    logic [bia_pkg::STATUS_W-1:0] status;
    bia_pkg::rid_t                result_id;
    bia_pkg::grp_t                group_index;
    bia_pkg::mask_t               deleted_mask;
    bia_pkg::mask_t               created_mask;
    logic                         last_word;

    bit busy_mode = 1'b1;
    int idle_cycles = 0;
    id_allocation_tracker tracker = new();

    always #2 clk = ~clk;

    bitmap_id_allocator_deferred_commit u_top (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .kind(kind),
        .target_id(target_id),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .status(status),
        .result_id(result_id),
        .group_index(group_index),
        .deleted_mask(deleted_mask),
        .created_mask(created_mask),
        .last(last_word)
    );

    function int pick_gap();
        int r;
        if (!busy_mode)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_word(logic [bia_pkg::KIND_W-1:0] k, int e);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind <= k;
        target_id <= bia_pkg::eid_t'(e);
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        tracker.note_request(k, bia_pkg::eid_t'(e));
    endtask

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            tracker.check_reply(status, result_id, group_index, deleted_mask, created_mask,
                                last_word);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall))
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        int len;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (busy_mode && $urandom_range(0, 99) < 30)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
                out_stall <= 1'b1;
                repeat (len) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int r;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(bia_pkg::KIND_QUERY, 0);
        send_word(bia_pkg::KIND_REMOVE, 0);
        send_word(bia_pkg::KIND_REMOVE, 1023);
        send_word(bia_pkg::KIND_COMMIT, 1023);
        send_word(bia_pkg::KIND_CREATE, 0);
        send_word(bia_pkg::KIND_CREATE, 1023);
        send_word(bia_pkg::KIND_REMOVE, 1);
        send_word(bia_pkg::KIND_QUERY, 0);
        send_word(bia_pkg::KIND_COMMIT, 0);
        send_word(bia_pkg::KIND_QUERY, 0);
        send_word(bia_pkg::KIND_QUERY, 1);
        send_word(bia_pkg::KIND_QUERY, 2);
        send_word(bia_pkg::KIND_QUERY, 1023);
        send_word(bia_pkg::KIND_REMOVE, 1);
        send_word(bia_pkg::KIND_REMOVE, 1);
        send_word(bia_pkg::KIND_CREATE, 512);
        send_word(bia_pkg::KIND_COMMIT, 0);
        send_word(bia_pkg::KIND_CREATE, 0);
        send_word(bia_pkg::KIND_REMOVE, 2);
        send_word(bia_pkg::KIND_COMMIT, 341);

        for (int n = 0; n < 376; n++)
        begin
            busy_mode = !(n >= 150 && n < 220);
            r = $urandom_range(0, 99);
            if (r < 40)
                send_word(bia_pkg::KIND_CREATE, $urandom_range(0, 1023));
            else if (r < 65)
                send_word(bia_pkg::KIND_REMOVE,
                          ($urandom_range(0, 3) != 0) ? tracker.pick_live()
                                                      : $urandom_range(0, 1023));
            else if (r < 75)
                send_word(bia_pkg::KIND_COMMIT, $urandom_range(0, 1023));
            else
                send_word(bia_pkg::KIND_QUERY,
                          ($urandom_range(0, 1) != 0) ? tracker.pick_live() - 1
                                                      : $urandom_range(0, 1023));
        end
        busy_mode = 1'b1;

        send_word(bia_pkg::KIND_CREATE, 7);
        send_word(bia_pkg::KIND_COMMIT, 0);
        send_word(bia_pkg::KIND_CREATE, 0);
        send_word(bia_pkg::KIND_QUERY, 1022);
        send_word(bia_pkg::KIND_QUERY, 1023);
        send_word(bia_pkg::KIND_REMOVE, 1023);
        send_word(bia_pkg::KIND_REMOVE, 5);
        send_word(bia_pkg::KIND_REMOVE, 5);
        send_word(bia_pkg::KIND_CREATE, 0);
        send_word(bia_pkg::KIND_COMMIT, 0);
        send_word(bia_pkg::KIND_CREATE, 0);
        send_word(bia_pkg::KIND_CREATE, 0);
        send_word(bia_pkg::KIND_CREATE, 0);
        send_word(bia_pkg::KIND_COMMIT, 0);
        in_valid <= 1'b0;

        while (tracker.awaited_replies.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (tracker.mismatches == 0 && tracker.awaited_replies.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+src
src/bia_pkg.sv
src/bia_front.sv
src/bia_back.sv
src/bitmap_id_allocator_deferred_commit.sv
sim/testbench.sv
